/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/slc_pkg.sv */
// types and constants of the sample logic comparator
package slc_pkg;

	localparam int unsigned SampleWidth = 32;
	localparam int unsigned CfgDataWidth = 32;
	localparam int unsigned CfgIdxWidth = 3;

	typedef enum logic [3:0] {
		OP_THRESHOLD  = 4'd0,
		OP_HYSTERESIS = 4'd1,
		OP_EDGE       = 4'd2,
		OP_AND        = 4'd3,
		OP_OR         = 4'd4,
		OP_XOR        = 4'd5,
		OP_NOT        = 4'd6,
		OP_NAND       = 4'd7,
		OP_NOR        = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		EDGE_RISE = 2'd0,
		EDGE_FALL = 2'd1,
		EDGE_BOTH = 2'd2
	} edge_kind_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_OPERATOR_SEL    = 3'd0,
		REG_THRESHOLD_LEVEL = 3'd1,
		REG_LOW_LEVEL       = 3'd2,
		REG_HIGH_LEVEL      = 3'd3,
		REG_EDGE_KIND       = 3'd4
	} cfg_reg_t;

	localparam logic signed [SampleWidth-1:0] ThresholdReset = 32'sd32768;
	localparam logic signed [SampleWidth-1:0] LowReset = 32'sd29491;
	localparam logic signed [SampleWidth-1:0] HighReset = 32'sd32768;

endpackage

/* rtl/sample_logic_comparator.sv */
// sample_logic_comparator: each sample goes through the input and result registers
// throughput one sample per cycle while the output is not stalled: an input register feeds
// one level of compare logic and a result register; the next sample enters while a result
// waits to be taken; async reset clears valids, hysteresis bit, prior sample and prior output,
// and loads the register defaults (threshold 0.5, low 0.45, high 0.5, both edges, threshold op)
module sample_logic_comparator
	import slc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CfgIdxWidth-1:0]        cfg_idx,
	input  logic [CfgDataWidth-1:0]       cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SampleWidth-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          logic_out,
	output logic                          changed,
	output logic                          became_true,
	output logic                          became_false
);

	logic [3:0]                    operator_sel_q;
	logic signed [SampleWidth-1:0] threshold_level_q;
	logic signed [SampleWidth-1:0] low_level_q;
	logic signed [SampleWidth-1:0] high_level_q;
	logic [1:0]                    edge_kind_q;

	logic                          valid_s1;
	logic signed [SampleWidth-1:0] sample_s1;

	logic                          hyst_q;
	logic signed [SampleWidth-1:0] prior_sample_q;
	logic                          prior_out_q;

	logic                          out_valid_q;
	logic                          logic_out_q;
	logic                          changed_q;
	logic                          became_true_q;
	logic                          became_false_q;

	logic out_busy;
	logic load_s1;
	logic advance;
	logic cur;
	logic was;
	logic hyst_next;
	logic res;
	logic chg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operator_sel_q    <= OP_THRESHOLD;
			threshold_level_q <= ThresholdReset;
			low_level_q       <= LowReset;
			high_level_q      <= HighReset;
			edge_kind_q       <= EDGE_BOTH;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_OPERATOR_SEL:    operator_sel_q <= cfg_data[3:0];
				REG_THRESHOLD_LEVEL: threshold_level_q <= cfg_data;
				REG_LOW_LEVEL:       low_level_q <= cfg_data;
				REG_HIGH_LEVEL:      high_level_q <= cfg_data;
				REG_EDGE_KIND:       edge_kind_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign out_busy = out_valid_q && out_stall;
	assign in_stall = valid_s1 && out_busy;
	assign load_s1  = in_valid && !in_stall;
	assign advance  = valid_s1 && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sample_s1 <= sample;
		end
	end

	always_comb begin
		cur       = sample_s1 > threshold_level_q;
		was       = prior_sample_q > threshold_level_q;
		hyst_next = hyst_q;
		res       = cur;
		case (operator_sel_q)
			OP_HYSTERESIS: begin
				if (sample_s1 > high_level_q) begin
					hyst_next = 1'b1;
				end else if (sample_s1 < low_level_q) begin
					hyst_next = 1'b0;
				end
				res = hyst_next;
			end
			OP_EDGE: begin
				res = 1'b0;
				if (cur != was) begin
					case (edge_kind_q)
						EDGE_RISE: res = cur;
						EDGE_FALL: res = !cur;
						default:   res = 1'b1;
					endcase
				end
			end
			OP_AND:  res = cur && prior_out_q;
			OP_OR:   res = cur || prior_out_q;
			OP_XOR:  res = cur ^ prior_out_q;
			OP_NOT:  res = !cur;
			OP_NAND: res = !(cur && prior_out_q);
			OP_NOR:  res = !(cur || prior_out_q);
			default: res = cur;
		endcase
		chg = res ^ prior_out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q         <= 1'b0;
			prior_sample_q <= '0;
			prior_out_q    <= 1'b0;
		end else if (advance) begin
			hyst_q         <= hyst_next;
			prior_sample_q <= sample_s1;
			prior_out_q    <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_busy) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register, loaded on each transfer out of the input stage
	always_ff @(posedge clk) begin
		if (advance) begin
			logic_out_q    <= res;
			changed_q      <= chg;
			became_true_q  <= chg && res;
			became_false_q <= chg && !res;
		end
	end

	assign out_valid    = out_valid_q;
	assign logic_out    = logic_out_q;
	assign changed      = changed_q;
	assign became_true  = became_true_q;
	assign became_false = became_false_q;

endmodule

/* rtl/slc_checker.sv */
// port-level checks of the sample logic comparator and their bind
`include "assert_macros.svh"

module slc_checker
	import slc_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [CfgIdxWidth-1:0]        cfg_idx,
	input logic [CfgDataWidth-1:0]       cfg_data,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic signed [SampleWidth-1:0] sample,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          logic_out,
	input logic                          changed,
	input logic                          became_true,
	input logic                          became_false
);

	logic unused_ok;
	assign unused_ok = cfg_we ^ (|cfg_idx) ^ (|cfg_data) ^ in_valid ^ in_stall ^ (|sample);

	`ASSERT_SAME(a_flags_exclusive, clk, arst_n, out_valid, !(became_true && became_false))
	`ASSERT_SAME(a_changed_split, clk, arst_n, out_valid, changed == (became_true || became_false))
	`ASSERT_SAME(a_true_level, clk, arst_n, out_valid && became_true, logic_out)
	`ASSERT_SAME(a_false_level, clk, arst_n, out_valid && became_false, !logic_out)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(logic_out))

endmodule

bind sample_logic_comparator slc_checker u_slc_checker (.*);
